FILE: hw/rtl/wavhdr_pkg.sv
// ----------------------------------------------------------------------------
// wavhdr_pkg
// Types, codes and tag constants for the WAV header stream parser.
// ----------------------------------------------------------------------------
package wavhdr_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_BODY_LEN = 32'd16;
  localparam logic [15:0] EIGHT_BITS   = 16'd8;
  localparam logic [15:0] MONO_CHANS   = 16'd1;

  typedef enum logic [1:0] {
    ACT_BYTE    = 2'd0,
    ACT_END     = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_RIFF_TAG  = 3'd0,
    ERR_WAVE_TAG  = 3'd1,
    ERR_FMT_TAG   = 3'd2,
    ERR_FMT_SHORT = 3'd3,
    ERR_NEG_SIZE  = 3'd4,
    ERR_ZERO_DATA = 3'd5,
    ERR_TRUNCATED = 3'd6
  } err_t;

  typedef enum logic [3:0] {
    PH_RIFF    = 4'd0,
    PH_RSIZE   = 4'd1,
    PH_WAVE    = 4'd2,
    PH_FMT     = 4'd3,
    PH_FSIZE   = 4'd4,
    PH_FBODY   = 4'd5,
    PH_FSKIP   = 4'd6,
    PH_CTAG    = 4'd7,
    PH_CSIZE   = 4'd8,
    PH_CSKIP   = 4'd9,
    PH_DSIZE   = 4'd10,
    PH_PAYLOAD = 4'd11,
    PH_DONE    = 4'd12,
    PH_ERROR   = 4'd13
  } phase_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        last_payload;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] samp_rate;
    logic [31:0] bytes_per_sec;
    logic [15:0] sample_width;
    logic [31:0] data_size;
    logic [1:0]  format_class;
    err_t        error_code;
  } out_item_t;

endpackage

FILE: hw/rtl/wavhdr_if.sv
// ----------------------------------------------------------------------------
// wavhdr_if
// Valid/ready channels for file bytes in and parse results out.
// ----------------------------------------------------------------------------
interface wavhdr_in_if (input logic clk);
  logic                 valid;
  logic                 ready;
  wavhdr_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface wavhdr_out_if (input logic clk);
  logic                  valid;
  logic                  ready;
  wavhdr_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/wav_header_stream_parser.sv
// ----------------------------------------------------------------------------
// wav_header_stream_parser
// Byte-serial RIFF/WAV header parser: checks tags, latches the fmt fields,
// skips other chunks, reports the header or any error and passes the data bytes through.
// ----------------------------------------------------------------------------
//   port     | dir | payload                         | notes
//   ---------+-----+---------------------------------+--------------------------
//   bytes    | in  | action, data_byte               | one file byte or command
//   results  | out | kind, payload/header/error flds | at most one per byte in
//
// One item per cycle while the skid register is empty: each byte updates the
// phase, counter and field registers; its result, if any, is in the output
// register on the next cycle. While the output stalls, bytes keep flowing until
// one more result is parked in the skid register; bytes is then held off until
// that entry has moved up into the output register.
// Synchronous reset returns the parser to expecting the RIFF tag.
module wav_header_stream_parser (
  input  logic               clk,
  input  logic               rst,
  wavhdr_in_if.sink          bytes,
  wavhdr_out_if.source       results
);

  wavhdr_pkg::phase_t    phase, phase_next;
  logic [31:0]           cnt, cnt_next;
  logic [31:0]           word, word_next;
  logic [15:0]           fmt_tag, fmt_tag_next;
  logic [15:0]           chans, chans_next;
  logic [31:0]           srate, srate_next;
  logic [31:0]           brate, brate_next;
  logic [15:0]           sbits, sbits_next;
  logic [31:0]           dsize, dsize_next;

  wavhdr_pkg::out_item_t res, skid, new_res;
  logic                  res_valid, skid_valid, new_has;
  logic                  in_fire;
  logic [31:0]           pushed;
  logic                  word_done;
  logic [3:0]            k;

  assign bytes.ready     = !skid_valid;
  assign in_fire         = bytes.valid && bytes.ready;
  assign results.valid   = res_valid;
  assign results.payload = res;

  assign pushed    = {bytes.payload.data_byte, word[31:8]};
  assign word_done = (cnt >= 32'd3);
  assign k         = cnt[3:0];

  always_comb begin
    phase_next   = phase;
    cnt_next     = cnt;
    word_next    = word;
    fmt_tag_next = fmt_tag;
    chans_next   = chans;
    srate_next   = srate;
    brate_next   = brate;
    sbits_next   = sbits;
    dsize_next   = dsize;
    new_has      = 1'b0;
    new_res      = '0;

    case (bytes.payload.action)
      wavhdr_pkg::ACT_RESTART: begin
        phase_next   = wavhdr_pkg::PH_RIFF;
        cnt_next     = '0;
        word_next    = '0;
        fmt_tag_next = '0;
        chans_next   = '0;
        srate_next   = '0;
        brate_next   = '0;
        sbits_next   = '0;
        dsize_next   = '0;
      end
      wavhdr_pkg::ACT_END: begin
        if (phase != wavhdr_pkg::PH_DONE && phase != wavhdr_pkg::PH_ERROR) begin
          phase_next         = wavhdr_pkg::PH_ERROR;
          cnt_next           = '0;
          new_has            = 1'b1;
          new_res.kind       = wavhdr_pkg::KIND_ERROR;
          new_res.error_code = wavhdr_pkg::ERR_TRUNCATED;
        end
      end
      wavhdr_pkg::ACT_BYTE: begin
        // word-field phases share the shift-in and 4-byte count
        if (phase == wavhdr_pkg::PH_RIFF || phase == wavhdr_pkg::PH_RSIZE ||
            phase == wavhdr_pkg::PH_WAVE || phase == wavhdr_pkg::PH_FMT ||
            phase == wavhdr_pkg::PH_FSIZE || phase == wavhdr_pkg::PH_CTAG ||
            phase == wavhdr_pkg::PH_CSIZE || phase == wavhdr_pkg::PH_DSIZE) begin
          word_next = pushed;
          cnt_next  = word_done ? 32'd0 : cnt + 32'd1;
        end
        unique case (phase)
          wavhdr_pkg::PH_RIFF: begin
            if (word_done) begin
              if (pushed != wavhdr_pkg::TAG_RIFF) begin
                phase_next         = wavhdr_pkg::PH_ERROR;
                new_has            = 1'b1;
                new_res.kind       = wavhdr_pkg::KIND_ERROR;
                new_res.error_code = wavhdr_pkg::ERR_RIFF_TAG;
              end else begin
                phase_next = wavhdr_pkg::PH_RSIZE;
              end
            end
          end
          wavhdr_pkg::PH_RSIZE: begin
            if (word_done) phase_next = wavhdr_pkg::PH_WAVE;
          end
          wavhdr_pkg::PH_WAVE: begin
            if (word_done) begin
              if (pushed != wavhdr_pkg::TAG_WAVE) begin
                phase_next         = wavhdr_pkg::PH_ERROR;
                new_has            = 1'b1;
                new_res.kind       = wavhdr_pkg::KIND_ERROR;
                new_res.error_code = wavhdr_pkg::ERR_WAVE_TAG;
              end else begin
                phase_next = wavhdr_pkg::PH_FMT;
              end
            end
          end
          wavhdr_pkg::PH_FMT: begin
            if (word_done) begin
              if (pushed != wavhdr_pkg::TAG_FMT) begin
                phase_next         = wavhdr_pkg::PH_ERROR;
                new_has            = 1'b1;
                new_res.kind       = wavhdr_pkg::KIND_ERROR;
                new_res.error_code = wavhdr_pkg::ERR_FMT_TAG;
              end else begin
                phase_next = wavhdr_pkg::PH_FSIZE;
              end
            end
          end
          wavhdr_pkg::PH_FSIZE: begin
            if (word_done) begin
              dsize_next = pushed;
              phase_next = wavhdr_pkg::PH_FBODY;
            end
          end
          wavhdr_pkg::PH_FBODY: begin
            word_next = pushed;
            cnt_next  = {28'd0, k} + 32'd1;
            case (k)
              4'd1:  fmt_tag_next = pushed[31:16];
              4'd3:  chans_next   = pushed[31:16];
              4'd7:  srate_next   = pushed;
              4'd11: brate_next   = pushed;
              4'd15: begin
                sbits_next = pushed[31:16];
                if (dsize[31] || dsize < wavhdr_pkg::FMT_BODY_LEN) begin
                  phase_next         = wavhdr_pkg::PH_ERROR;
                  cnt_next           = '0;
                  new_has            = 1'b1;
                  new_res.kind       = wavhdr_pkg::KIND_ERROR;
                  new_res.error_code = wavhdr_pkg::ERR_FMT_SHORT;
                end else begin
                  dsize_next = '0;
                  cnt_next   = dsize - wavhdr_pkg::FMT_BODY_LEN;
                  phase_next = (dsize == wavhdr_pkg::FMT_BODY_LEN) ?
                               wavhdr_pkg::PH_CTAG : wavhdr_pkg::PH_FSKIP;
                end
              end
              default: ;
            endcase
          end
          wavhdr_pkg::PH_FSKIP, wavhdr_pkg::PH_CSKIP: begin
            cnt_next = cnt - 32'd1;
            if (cnt == 32'd1) phase_next = wavhdr_pkg::PH_CTAG;
          end
          wavhdr_pkg::PH_CTAG: begin
            if (word_done) begin
              phase_next = (pushed == wavhdr_pkg::TAG_DATA) ?
                           wavhdr_pkg::PH_DSIZE : wavhdr_pkg::PH_CSIZE;
            end
          end
          wavhdr_pkg::PH_CSIZE: begin
            if (word_done) begin
              if (pushed[31]) begin
                phase_next         = wavhdr_pkg::PH_ERROR;
                new_has            = 1'b1;
                new_res.kind       = wavhdr_pkg::KIND_ERROR;
                new_res.error_code = wavhdr_pkg::ERR_NEG_SIZE;
              end else begin
                cnt_next   = pushed;
                phase_next = (pushed == 32'd0) ? wavhdr_pkg::PH_CTAG : wavhdr_pkg::PH_CSKIP;
              end
            end
          end
          wavhdr_pkg::PH_DSIZE: begin
            if (word_done) begin
              new_has = 1'b1;
              if (pushed == 32'd0) begin
                phase_next         = wavhdr_pkg::PH_ERROR;
                new_res.kind       = wavhdr_pkg::KIND_ERROR;
                new_res.error_code = wavhdr_pkg::ERR_ZERO_DATA;
              end else begin
                dsize_next            = pushed;
                cnt_next              = pushed;
                phase_next            = wavhdr_pkg::PH_PAYLOAD;
                new_res.kind          = wavhdr_pkg::KIND_HEADER;
                new_res.audio_format  = fmt_tag;
                new_res.channel_count = chans;
                new_res.samp_rate     = srate;
                new_res.bytes_per_sec = brate;
                new_res.sample_width  = sbits;
                new_res.data_size     = pushed;
                new_res.format_class  = {chans != wavhdr_pkg::MONO_CHANS,
                                         sbits != wavhdr_pkg::EIGHT_BITS};
              end
            end
          end
          wavhdr_pkg::PH_PAYLOAD: begin
            new_has              = 1'b1;
            new_res.kind         = wavhdr_pkg::KIND_PAYLOAD;
            new_res.payload_byte = bytes.payload.data_byte;
            new_res.last_payload = (cnt <= 32'd1);
            if (cnt <= 32'd1) begin
              cnt_next   = '0;
              phase_next = wavhdr_pkg::PH_DONE;
            end else begin
              cnt_next = cnt - 32'd1;
            end
          end
          wavhdr_pkg::PH_DONE, wavhdr_pkg::PH_ERROR: ;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wavhdr_pkg::PH_RIFF;
      cnt   <= '0;
    end else if (in_fire) begin
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word    <= '0;
      fmt_tag <= '0;
      chans   <= '0;
      srate   <= '0;
      brate   <= '0;
      sbits   <= '0;
      dsize   <= '0;
    end else if (in_fire) begin
      word    <= word_next;
      fmt_tag <= fmt_tag_next;
      chans   <= chans_next;
      srate   <= srate_next;
      brate   <= brate_next;
      sbits   <= sbits_next;
      dsize   <= dsize_next;
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_valid && !results.ready) begin
      if (in_fire && new_has) begin
        skid       <= new_res;
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      res        <= skid;
      res_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      res       <= new_res;
      res_valid <= in_fire && new_has;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry held without an output result");

  a_restart_phase: assert property (@(posedge clk) disable iff (rst)
    in_fire && bytes.payload.action == wavhdr_pkg::ACT_RESTART |=>
      phase == wavhdr_pkg::PH_RIFF && cnt == 32'd0)
    else $error("restart did not return parser to RIFF tag");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == wavhdr_pkg::PH_PAYLOAD |-> cnt != 32'd0)
    else $error("payload phase with zero bytes left");

  a_done_count: assert property (@(posedge clk) disable iff (rst)
    phase == wavhdr_pkg::PH_DONE || phase == wavhdr_pkg::PH_ERROR |-> cnt == 32'd0)
    else $error("count not cleared after completion or error");

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives whole WAV files, broken files and stray commands into the parser
// byte by byte, tracks the parse in a scoreboard and checks every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wavhdr_pkg::*;

  localparam int          ITEM_TARGET  = 1450;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES = 30;
  localparam int          FILLER_CAP   = 64;
  localparam logic [31:0] TAG_LIST     = 32'h5453_494C;

  typedef enum int {
    FLAW_NONE,
    FLAW_RIFF,
    FLAW_WAVE,
    FLAW_FMT_TAG,
    FLAW_FMT_SHORT,
    FLAW_FMT_NEG,
    FLAW_CHUNK_NEG,
    FLAW_ZERO_DATA,
    FLAW_CUT,
    FLAW_HUGE
  } file_flaw_t;

  // Tracks the parse of the byte stream and holds the results still owed.
  class wav_parse_scoreboard;
    phase_t      phase;
    logic [31:0] field_count;
    logic [31:0] shift_word;
    logic [15:0] fmt_code;
    logic [15:0] chan_count;
    logic [31:0] rate;
    logic [31:0] brate;
    logic [15:0] sample_bits;
    logic [31:0] size_word;
    out_item_t   expected_results[$];
    int          mismatches;
    int          header_reports;
    int          payload_bytes;
    int          parse_errors;
    logic [7:0]  error_codes_seen;

    function new();
      clear_state();
      mismatches       = 0;
      header_reports   = 0;
      payload_bytes    = 0;
      parse_errors     = 0;
      error_codes_seen = '0;
    endfunction

    function void clear_state();
      phase       = PH_RIFF;
      field_count = '0;
      shift_word  = '0;
      fmt_code    = '0;
      chan_count  = '0;
      rate        = '0;
      brate       = '0;
      sample_bits = '0;
      size_word   = '0;
    endfunction

    // Little-endian field assembly; true once four bytes are in.
    function bit shift_in(logic [7:0] b);
      shift_word  = {b, shift_word[31:8]};
      field_count = field_count + 1;
      if (field_count >= 4) begin
        field_count = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit predict_parse(input action_t a, input logic [7:0] b,
                               output out_item_t r);
      bit          emit;
      bit          failed;
      err_t        code;
      logic [31:0] k;
      r      = '0;
      emit   = 1'b0;
      failed = 1'b0;
      code   = ERR_RIFF_TAG;
      case (a)
        ACT_RESTART: clear_state();
        ACT_END: begin
          if (phase != PH_DONE && phase != PH_ERROR) begin
            failed = 1'b1;
            code   = ERR_TRUNCATED;
          end
        end
        ACT_BYTE: begin
          case (phase)
            PH_RIFF: begin
              if (shift_in(b)) begin
                if (shift_word != TAG_RIFF) begin
                  failed = 1'b1;
                  code   = ERR_RIFF_TAG;
                end else begin
                  phase = PH_RSIZE;
                end
              end
            end
            PH_RSIZE: if (shift_in(b)) phase = PH_WAVE;
            PH_WAVE: begin
              if (shift_in(b)) begin
                if (shift_word != TAG_WAVE) begin
                  failed = 1'b1;
                  code   = ERR_WAVE_TAG;
                end else begin
                  phase = PH_FMT;
                end
              end
            end
            PH_FMT: begin
              if (shift_in(b)) begin
                if (shift_word != TAG_FMT) begin
                  failed = 1'b1;
                  code   = ERR_FMT_TAG;
                end else begin
                  phase = PH_FSIZE;
                end
              end
            end
            PH_FSIZE: begin
              if (shift_in(b)) begin
                size_word = shift_word;
                phase     = PH_FBODY;
              end
            end
            PH_FBODY: begin
              shift_word  = {b, shift_word[31:8]};
              k           = {28'd0, field_count[3:0]};
              field_count = k + 1;
              case (k)
                1:  fmt_code   = shift_word[31:16];
                3:  chan_count = shift_word[31:16];
                7:  rate       = shift_word;
                11: brate      = shift_word;
                15: begin
                  sample_bits = shift_word[31:16];
                  // size field doubles as the fmt chunk length here
                  if (size_word[31] || size_word < FMT_BODY_LEN) begin
                    failed = 1'b1;
                    code   = ERR_FMT_SHORT;
                  end else begin
                    k           = size_word - FMT_BODY_LEN;
                    size_word   = '0;
                    field_count = k;
                    phase       = (k == 0) ? PH_CTAG : PH_FSKIP;
                  end
                end
                default: ;
              endcase
            end
            PH_FSKIP, PH_CSKIP: begin
              field_count = field_count - 1;
              if (field_count == 0) phase = PH_CTAG;
            end
            PH_CTAG: begin
              if (shift_in(b)) phase = (shift_word == TAG_DATA) ? PH_DSIZE : PH_CSIZE;
            end
            PH_CSIZE: begin
              if (shift_in(b)) begin
                if (shift_word[31]) begin
                  failed = 1'b1;
                  code   = ERR_NEG_SIZE;
                end else begin
                  field_count = shift_word;
                  phase       = (shift_word == 0) ? PH_CTAG : PH_CSKIP;
                end
              end
            end
            PH_DSIZE: begin
              if (shift_in(b)) begin
                if (shift_word == 0) begin
                  failed = 1'b1;
                  code   = ERR_ZERO_DATA;
                end else begin
                  size_word       = shift_word;
                  field_count     = shift_word;
                  phase           = PH_PAYLOAD;
                  r.kind          = KIND_HEADER;
                  r.audio_format  = fmt_code;
                  r.channel_count = chan_count;
                  r.samp_rate     = rate;
                  r.bytes_per_sec = brate;
                  r.sample_width  = sample_bits;
                  r.data_size     = size_word;
                  r.format_class  = {chan_count != MONO_CHANS, sample_bits != EIGHT_BITS};
                  emit            = 1'b1;
                end
              end
            end
            PH_PAYLOAD: begin
              r.kind         = KIND_PAYLOAD;
              r.payload_byte = b;
              r.last_payload = (field_count <= 1);
              if (field_count <= 1) begin
                field_count = '0;
                phase       = PH_DONE;
              end else begin
                field_count = field_count - 1;
              end
              emit = 1'b1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      if (failed) begin
        phase        = PH_ERROR;
        field_count  = '0;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        emit         = 1'b1;
      end
      return emit;
    endfunction

    // Returns whether the item did anything beyond being ignored.
    function bit note_input(action_t a, logic [7:0] b);
      bit        live;
      out_item_t r;
      live = (a == ACT_RESTART) ||
             (a != ACT_NONE && phase != PH_DONE && phase != PH_ERROR);
      if (predict_parse(a, b, r)) expected_results.push_back(r);
      return live;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report(string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result of kind %0d with nothing expected", got.kind));
        return;
      end
      want = expected_results.pop_front();
      check_field("kind",          32'(got.kind),          32'(want.kind));
      check_field("payload_byte",  32'(got.payload_byte),  32'(want.payload_byte));
      check_field("last_payload",  32'(got.last_payload),  32'(want.last_payload));
      check_field("audio_format",  32'(got.audio_format),  32'(want.audio_format));
      check_field("channel_count", 32'(got.channel_count), 32'(want.channel_count));
      check_field("samp_rate",     got.samp_rate,          want.samp_rate);
      check_field("bytes_per_sec", got.bytes_per_sec,      want.bytes_per_sec);
      check_field("sample_width",  32'(got.sample_width),  32'(want.sample_width));
      check_field("data_size",     got.data_size,          want.data_size);
      check_field("format_class",  32'(got.format_class),  32'(want.format_class));
      check_field("error_code",    32'(got.error_code),    32'(want.error_code));
      case (want.kind)
        KIND_HEADER:  header_reports++;
        KIND_PAYLOAD: payload_bytes++;
        default: begin
          parse_errors++;
          error_codes_seen[want.error_code] = 1'b1;
        end
      endcase
    endtask

    task finish_check();
      if (expected_results.size() != 0)
        report($sformatf("%0d results never arrived", expected_results.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  wavhdr_in_if  in_if  (clk);
  wavhdr_out_if out_if (clk);

  wav_header_stream_parser dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (in_if),
    .results (out_if)
  );

  always #10 clk = ~clk;

  wav_parse_scoreboard sb;
  int  live_items = 0;
  int  sent_items = 0;
  int  file_count = 0;
  int  bytes_left = -1;   // -1: no cut, else bytes still allowed in this file
  bit  noisy      = 1'b0;
  bit  tx_burst   = 1'b0;
  bit  rx_burst   = 1'b0;
  bit  squeeze_req = 1'b0;

  function automatic logic [31:0] flip_bit(logic [31:0] w);
    return w ^ (32'h1 << $urandom_range(0, 31));
  endfunction

  task automatic send_item(action_t a, logic [7:0] b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= '{action: a, data_byte: b};
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent_items++;
    if (sb.note_input(a, b)) live_items++;
  endtask

  task automatic send_byte(logic [7:0] b);
    if (bytes_left == 0) return;
    if (bytes_left > 0) bytes_left--;
    if (noisy && $urandom_range(0, 39) == 0) send_item(ACT_NONE, 8'($urandom));
    send_item(ACT_BYTE, b);
  endtask

  task automatic send_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
  endtask

  // Body bytes of a skipped region or the data chunk; lengths over FILLER_CAP get 0 to 8 bytes.
  task automatic send_filler(logic [31:0] n);
    int cnt;
    cnt = (n > FILLER_CAP) ? $urandom_range(0, 8) : int'(n);
    repeat (cnt) send_byte(8'($urandom));
  endtask

  task automatic send_file(file_flaw_t flaw, bit squeeze);
    logic [31:0] fmt_size;
    logic [31:0] chunk_len;
    logic [31:0] chunk_tag;
    logic [31:0] data_len;
    logic [15:0] fmt_tag;
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] rate;
    int          chunks;
    int          huge_pick;

    file_count++;
    tx_burst  = squeeze || ($urandom_range(0, 4) == 0);
    huge_pick = $urandom_range(0, 2);
    send_item(ACT_RESTART, 8'($urandom));
    bytes_left = (flaw == FLAW_CUT) ? $urandom_range(0, 70) : -1;

    send_word(flaw == FLAW_RIFF ? flip_bit(TAG_RIFF) : TAG_RIFF);
    send_word($urandom);
    send_word(flaw == FLAW_WAVE ? flip_bit(TAG_WAVE) : TAG_WAVE);
    send_word(flaw == FLAW_FMT_TAG ? flip_bit(TAG_FMT) : TAG_FMT);

    fmt_size = ($urandom_range(0, 3) == 0) ? 32'(16 + $urandom_range(1, 6)) : 32'd16;
    if (flaw == FLAW_FMT_SHORT) fmt_size = $urandom_range(0, 15);
    if (flaw == FLAW_FMT_NEG) fmt_size = $urandom | 32'h8000_0000;
    if (flaw == FLAW_HUGE && huge_pick == 0) fmt_size = 32'h7FFF_FFFF;
    send_word(fmt_size);

    fmt_tag = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd1;
    case ($urandom_range(0, 4))
      0, 1:    chans = 16'd1;
      2, 3:    chans = 16'd2;
      default: chans = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0, 1:    bits = 16'd8;
      2, 3:    bits = 16'd16;
      default: bits = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       rate = 32'd44100;
      1:       rate = 32'd8000;
      2:       rate = 32'd48000;
      default: rate = $urandom;
    endcase
    send_word({chans, fmt_tag});
    send_word(rate);
    send_word($urandom);
    send_word({bits, 16'($urandom)});
    send_filler((fmt_size[31] || fmt_size < FMT_BODY_LEN) ? 32'd0 : fmt_size - FMT_BODY_LEN);

    chunks = $urandom_range(0, 2);
    if ((flaw == FLAW_CHUNK_NEG || (flaw == FLAW_HUGE && huge_pick == 1)) && chunks == 0)
      chunks = 1;
    for (int i = 0; i < chunks; i++) begin
      chunk_tag = $urandom_range(0, 1) ? TAG_LIST : $urandom;
      if (chunk_tag == TAG_DATA) chunk_tag = chunk_tag ^ 32'h1;
      chunk_len = $urandom_range(0, 8);
      if (i == 0 && flaw == FLAW_CHUNK_NEG) chunk_len = $urandom | 32'h8000_0000;
      if (i == 0 && flaw == FLAW_HUGE && huge_pick == 1) chunk_len = 32'h7FFF_FFFF;
      send_word(chunk_tag);
      send_word(chunk_len);
      send_filler(chunk_len[31] ? 32'd0 : chunk_len);
    end

    // long receiver hold while the payload is sent, filling the skid register
    if (squeeze) squeeze_req = 1'b1;
    send_word(TAG_DATA);
    data_len = ($urandom_range(0, 5) == 0) ? 32'd1 : 32'($urandom_range(1, 24));
    if (squeeze) data_len = 32'd48;
    if (flaw == FLAW_ZERO_DATA) data_len = 32'd0;
    if (flaw == FLAW_HUGE && huge_pick == 2)
      data_len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h100);
    send_word(data_len);
    send_filler(data_len);

    repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
    if ($urandom_range(0, 3) != 0) send_item(ACT_END, 8'($urandom));
    if ($urandom_range(0, 5) == 0) send_item(ACT_END, 8'($urandom));
  endtask

  initial begin : receiver
    int gap;
    out_if.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 23) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      sb.check_result(out_if.payload);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    wait (rst == 1'b0);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("no item moved for %0d cycles", IDLE_LIMIT);
    $display("wav_header_stream_parser test failed");
    $finish;
  end

  initial begin : stimulus
    file_flaw_t flaw;
    sb = new();
    rst           = 1'b1;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // commands before any file, ignored bytes after an error, bad tags
    send_item(ACT_NONE, 8'hFF);
    send_item(ACT_END, 8'h00);
    send_item(ACT_BYTE, 8'hFF);
    send_item(ACT_END, 8'hFF);
    send_item(ACT_RESTART, 8'hFF);
    send_word(32'hFF00_FF00);
    send_item(ACT_RESTART, 8'h00);
    send_word(TAG_RIFF);
    send_word(32'hFFFF_FFFF);
    send_word(TAG_WAVE ^ 32'h8000_0000);
    send_item(ACT_RESTART, 8'h00);

    noisy = 1'b1;
    for (int f = 0; f <= int'(FLAW_HUGE); f++) send_file(file_flaw_t'(f), f == 0);
    while (sent_items < ITEM_TARGET) begin
      flaw = ($urandom_range(0, 9) < 5) ? FLAW_NONE
                                        : file_flaw_t'($urandom_range(1, int'(FLAW_HUGE)));
      send_file(flaw, file_count % 20 == 10);
    end
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.finish_check();

    $display("%0d files, %0d items sent (%0d live): %0d headers, %0d payload bytes",
             file_count, sent_items, live_items, sb.header_reports, sb.payload_bytes);
    $display("%0d parse errors, error codes hit (bit per code): %b",
             sb.parse_errors, sb.error_codes_seen[6:0]);
    if (sb.mismatches == 0) begin
      $display("wav_header_stream_parser test passed");
    end else begin
      $display("wav_header_stream_parser test failed");
    end
    $finish;
  end

endmodule
